>>> hw/rtl/ulst_pkg.sv
// Shared constants and types for the unsorted list table.
`default_nettype none

package ulst_pkg;

   // defaults for the top level parameters
   localparam int CAPACITY_DEF   = 16;
   localparam int ITEM_WIDTH_DEF = 32;

   // fixed field widths on the stream ports
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE       = 3'd1;
   localparam logic [OP_W-1:0] OP_RETRIEVE     = 3'd2;
   localparam logic [OP_W-1:0] OP_RESET_CURSOR = 3'd3;
   localparam logic [OP_W-1:0] OP_GET_NEXT     = 3'd4;
   localparam logic [OP_W-1:0] OP_MAKE_EMPTY   = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_PAST_END  = 2'd3;

   // control broadcast to every cell
   typedef struct packed {
      logic cmp_en;   // latch compare and cursor read results
      logic ins_en;   // shift toward tail, head takes the new value
      logic del_en;   // cells at or past the match pull from the tail side
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/unsorted_list_table_top.sv
// Top level of the unsorted list table: request intake, cell row, result register.
//
//  channel  | dir | ports                              | contents (low bit up)
//  ---------+-----+------------------------------------+-----------------------------------
//  request  | in  | req_tvalid/req_tready/tdata/tuser  | tuser: operation[2:0]
//           |     |                                    | tdata: item_value[31:0]
//  response | out | rsp_tvalid/rsp_tready/tdata        | tdata: item_out[31:0], found[32],
//           |     |                                    |   status[34:33], count[39:35],
//           |     |                                    |   at_end[40], zero fill [47:41]
//
//  Each request runs through accept, compare in every cell, then
//  execute (shift the cell row, update count and cursor, load the result).
//  The execute step waits while the result register still holds an untaken
//  response; a new request is taken once execute has run, so the next one
//  can be in compare while the previous response sits on the output.
//  Synchronous active-high reset empties the list and clears the cursor;
//  cell contents are not reset and are only read below the entry count.
`default_nettype none

module unsorted_list_table_top #(
   parameter int CAPACITY   = ulst_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = ulst_pkg::ITEM_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // item_value[31:0]
   input  wire logic [2:0]  req_tuser,   // operation[2:0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // item_out, found, status, count, at_end, zeros
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;

   // latched request
   logic [ulst_pkg::OP_W-1:0] op_ff;
   logic [ITEM_WIDTH-1:0]     val_ff;

   // list bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   // cell row
   ulst_pkg::cell_ctl_type ctl;
   logic [ITEM_WIDTH-1:0]  entry_w [CAPACITY];
   logic [ITEM_WIDTH-1:0]  rd_w    [CAPACITY];
   logic [CAPACITY-1:0]    hit_vec;
   logic [CAPACITY-1:0]    hit_lt_vec;
   logic [CAPACITY-1:0]    ge_vec;

   // execute-step results
   logic                              accept;
   logic                              fire;
   logic                              any_hit;
   logic                              any_hit_lt;
   logic [ITEM_WIDTH-1:0]             cur_item;
   logic [ITEM_WIDTH-1:0]             item_res;
   logic                              found_res;
   logic [ulst_pkg::STATUS_W-1:0]     status_res;
   logic                              ins_go;
   logic                              del_go;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign fire       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_tuser;
         val_ff <= ITEM_WIDTH'(req_tdata);
      end
   end

   // ---------------- cell row ----------------
   assign ctl.cmp_en = (state_ff == S_CMP);
   assign ctl.ins_en = fire && ins_go;
   assign ctl.del_en = fire && del_go;

   // cells at or past the first match: prefix OR of the hit vector
   assign ge_vec = hit_vec | ~(hit_vec - CAPACITY'(1));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] prev_w, next_w;
      if (i == 0) begin : g_head
         assign prev_w = '0;
      end else begin : g_body
         assign prev_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_w = '0;
      end else begin : g_inner
         assign next_w = entry_w[i+1];
      end

      ulst_cell #(
         .ITEM_WIDTH (ITEM_WIDTH),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .value_i     (val_ff),
         .count_i     (count_ff),
         .cursor_i    (cursor_ff),
         .prev_i      (prev_w),
         .next_i      (next_w),
         .shift_sel_i (ge_vec[i]),
         .entry_o     (entry_w[i]),
         .hit_o       (hit_vec[i]),
         .hit_lt_o    (hit_lt_vec[i]),
         .rd_o        (rd_w[i])
      );
   end

   // only the cell at the cursor drives a nonzero read value
   always_comb begin
      cur_item = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         cur_item = cur_item | rd_w[i];
      end
   end

   assign any_hit    = |hit_vec;
   assign any_hit_lt = |hit_lt_vec;

   // ---------------- execute step ----------------
   always_comb begin
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      item_res   = '0;
      found_res  = 1'b0;
      status_res = ulst_pkg::STAT_OK;
      ins_go     = 1'b0;
      del_go     = 1'b0;
      unique case (op_ff)
         ulst_pkg::OP_INSERT: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               status_res = ulst_pkg::STAT_FULL;
            end else begin
               ins_go    = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               cursor_in = cursor_ff + CNT_W'(1);
            end
         end
         ulst_pkg::OP_DELETE: begin
            if (!any_hit) begin
               status_res = ulst_pkg::STAT_NOT_FOUND;
            end else begin
               found_res = 1'b1;
               del_go    = 1'b1;
               count_in  = count_ff - CNT_W'(1);
               if (any_hit_lt) begin
                  cursor_in = cursor_ff - CNT_W'(1);
               end
            end
         end
         ulst_pkg::OP_RETRIEVE: begin
            // a hit holds exactly the searched value
            if (!any_hit) begin
               status_res = ulst_pkg::STAT_NOT_FOUND;
            end else begin
               found_res = 1'b1;
               item_res  = val_ff;
            end
         end
         ulst_pkg::OP_RESET_CURSOR: begin
            cursor_in = '0;
         end
         ulst_pkg::OP_GET_NEXT: begin
            if (cursor_ff >= count_ff) begin
               status_res = ulst_pkg::STAT_PAST_END;
            end else begin
               item_res  = cur_item;
               cursor_in = cursor_ff + CNT_W'(1);
            end
         end
         ulst_pkg::OP_MAKE_EMPTY: begin
            count_in  = '0;
            cursor_in = '0;
         end
         default: begin
            // unused codes leave everything alone
         end
      endcase
   end

   always_comb begin
      rsp_data_in = {7'd0,
                     (cursor_in >= count_in),
                     (ulst_pkg::COUNT_W)'(count_in),
                     status_res,
                     found_res,
                     (ulst_pkg::VALUE_W)'(item_res)};
   end

   // ---------------- sequencing ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_CMP;
         S_CMP:   state_in = S_EXEC;
         S_EXEC:  if (fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_cursor_bound : assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff)
      else $error("cursor beyond entry count");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      (fire && ins_go) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

   a_delete_hit : assert property (@(posedge clock) disable iff (reset)
      (fire && del_go) |-> (any_hit && (count_ff != '0)))
      else $error("delete shift without a live match");

endmodule

`default_nettype wire

>>> hw/rtl/ulst_cell.sv
// One list cell: holds one entry, compares it, shifts to/from its neighbors.
`default_nettype none

module ulst_cell #(
   parameter int ITEM_WIDTH = ulst_pkg::ITEM_WIDTH_DEF,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  wire logic                    clock,
   input  wire ulst_pkg::cell_ctl_type  ctl,
   input  wire logic [ITEM_WIDTH-1:0]   value_i,
   input  wire logic [CNT_W-1:0]        count_i,
   input  wire logic [CNT_W-1:0]        cursor_i,
   input  wire logic [ITEM_WIDTH-1:0]   prev_i,      // head side neighbor
   input  wire logic [ITEM_WIDTH-1:0]   next_i,      // tail side neighbor
   input  wire logic                    shift_sel_i, // at or past first match
   output logic      [ITEM_WIDTH-1:0]   entry_o,
   output logic                         hit_o,
   output logic                         hit_lt_o,    // hit ahead of the cursor
   output logic      [ITEM_WIDTH-1:0]   rd_o         // entry if at cursor, else 0
);

   localparam logic [CNT_W-1:0] IDX     = CNT_W'(INDEX);
   localparam bit               IS_HEAD = (INDEX == 0);

   logic [ITEM_WIDTH-1:0] entry_ff, entry_in;
   logic                  hit_ff, hit_in;
   logic                  hit_lt_ff, hit_lt_in;
   logic [ITEM_WIDTH-1:0] rd_ff, rd_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         entry_in = IS_HEAD ? value_i : prev_i;
      end else if (ctl.del_en && shift_sel_i) begin
         entry_in = next_i;
      end
   end

   always_comb begin
      hit_in    = (IDX < count_i) && (entry_ff == value_i);
      hit_lt_in = hit_in && (IDX < cursor_i);
      rd_in     = (IDX == cursor_i) ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.cmp_en) begin
         hit_ff    <= hit_in;
         hit_lt_ff <= hit_lt_in;
         rd_ff     <= rd_in;
      end
   end

   assign entry_o  = entry_ff;
   assign hit_o    = hit_ff;
   assign hit_lt_o = hit_lt_ff;
   assign rd_o     = rd_ff;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for the unsorted list table: a directed table, then random phases.
module tb_top;

   localparam int LIST_DEPTH  = ulst_pkg::CAPACITY_DEF;
   localparam int RANDOM_REQS = 1500;
   localparam int IDLE_LIMIT  = 3000;   // cycles with no request or response moving
   localparam int LONG_HOLD   = 300;    // receiver hold-off that backs the block up
   localparam int DRAIN_WAIT  = 12;     // settling wait after the final drain
   localparam int MAX_REPORTS = 40;

   // codes the block must treat as no-ops
   localparam logic [ulst_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [ulst_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [31:0]                   item_out;
      logic                          found;
      logic [ulst_pkg::STATUS_W-1:0] status;
      logic [ulst_pkg::COUNT_W-1:0]  count;
      logic                          at_end;
   } list_result_type;

   typedef struct packed {
      logic [ulst_pkg::OP_W-1:0] op;
      logic [31:0]               value;
      logic                      typed;   // 1: want holds the hand-written response
      list_result_type           want;
   } directed_row_type;

   typedef enum int {PH_FILL, PH_DRAIN, PH_WALK, PH_MIXED, PH_CLEAR} phase_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   // shadow copy of the list, updated as each request is accepted
   logic [31:0] shadow_entries [LIST_DEPTH];
   int          shadow_count;
   int          shadow_cursor;

   list_result_type  pending_results[$];
   directed_row_type directed_rows[$];
   logic [31:0]      value_pool [8];

   int error_count;
   int resp_count;
   int idle_cycles;
   int op_seen [8];
   int full_drops;
   int match_hits;
   int past_end_hits;
   bit burst_mode;
   bit long_hold_req;

   unsorted_list_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predictor: applies one operation to the shadow list and returns the response.
   function automatic list_result_type apply_list_op(input logic [ulst_pkg::OP_W-1:0] op,
                                                     input logic [31:0] value);
      list_result_type res;
      int hit;
      int i;
      res = '0;
      // first match counted from the head, or shadow_count on a miss
      hit = shadow_count;
      for (i = shadow_count - 1; i >= 0; i--)
         if (shadow_entries[i] == value) hit = i;
      case (op)
         ulst_pkg::OP_INSERT: begin
            if (shadow_count >= LIST_DEPTH) begin
               res.status = ulst_pkg::STAT_FULL;
            end else begin
               for (i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[0] = value;
               shadow_count++;
               shadow_cursor++;
            end
         end
         ulst_pkg::OP_DELETE: begin
            if (hit >= shadow_count) begin
               res.status = ulst_pkg::STAT_NOT_FOUND;
            end else begin
               res.found = 1'b1;
               for (i = hit; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               if (shadow_cursor > hit) shadow_cursor--;
            end
         end
         ulst_pkg::OP_RETRIEVE: begin
            if (hit >= shadow_count) begin
               res.status = ulst_pkg::STAT_NOT_FOUND;
            end else begin
               res.found    = 1'b1;
               res.item_out = shadow_entries[hit];
            end
         end
         ulst_pkg::OP_RESET_CURSOR: shadow_cursor = 0;
         ulst_pkg::OP_GET_NEXT: begin
            if (shadow_cursor >= shadow_count) begin
               res.status = ulst_pkg::STAT_PAST_END;
            end else begin
               res.item_out = shadow_entries[shadow_cursor];
               shadow_cursor++;
            end
         end
         ulst_pkg::OP_MAKE_EMPTY: begin
            shadow_count  = 0;
            shadow_cursor = 0;
         end
         default: ;
      endcase
      res.count  = shadow_count[ulst_pkg::COUNT_W-1:0];
      res.at_end = (shadow_cursor >= shadow_count);
      return res;
   endfunction

   task automatic add_row(input logic [ulst_pkg::OP_W-1:0] op, input logic [31:0] value,
                          input logic typed, input logic [31:0] item_out, input logic found,
                          input logic [ulst_pkg::STATUS_W-1:0] status,
                          input logic [ulst_pkg::COUNT_W-1:0] count,
                          input logic at_end);
      directed_row_type row;
      row.op            = op;
      row.value         = value;
      row.typed         = typed;
      row.want.item_out = item_out;
      row.want.found    = found;
      row.want.status   = status;
      row.want.count    = count;
      row.want.at_end   = at_end;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR: response %0d, %s: got 0x%0h, expected 0x%0h",
                  resp_count, what, got, want);
   endtask

   // Offers one request from a falling edge, returns at the falling edge after it is taken.
   task automatic send_request(input logic [ulst_pkg::OP_W-1:0] op, input logic [31:0] value,
                               input logic typed, input list_result_type typed_want);
      list_result_type predicted;
      int gap;
      int r;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!burst_mode) begin
         if (r >= 98)      gap = $urandom_range(20, 60);
         else if (r >= 90) gap = $urandom_range(4, 10);
         else if (r >= 55) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(op, value);
      pending_results.push_back(typed ? typed_want : predicted);
      op_seen[op]++;
      if (predicted.status == ulst_pkg::STAT_FULL)     full_drops++;
      if (predicted.found)                             match_hits++;
      if (predicted.status == ulst_pkg::STAT_PAST_END) past_end_hits++;
      @(negedge clock);
   endtask

   // Sender pause: stop offering and let every outstanding response come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [ulst_pkg::OP_W-1:0] pick_op(input phase_kind_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         PH_FILL: begin
            if (r < 60) return ulst_pkg::OP_INSERT;
            if (r < 72) return ulst_pkg::OP_RETRIEVE;
            if (r < 82) return ulst_pkg::OP_DELETE;
            if (r < 92) return ulst_pkg::OP_GET_NEXT;
            if (r < 96) return ulst_pkg::OP_RESET_CURSOR;
            return r[0] ? OP_SPARE_LO : OP_SPARE_HI;
         end
         PH_DRAIN: begin
            if (r < 50) return ulst_pkg::OP_DELETE;
            if (r < 70) return ulst_pkg::OP_RETRIEVE;
            if (r < 80) return ulst_pkg::OP_INSERT;
            if (r < 92) return ulst_pkg::OP_GET_NEXT;
            if (r < 97) return ulst_pkg::OP_RESET_CURSOR;
            return ulst_pkg::OP_MAKE_EMPTY;
         end
         PH_WALK: begin
            // iterate the list, disturbed now and then by inserts and deletes
            if (r < 55) return ulst_pkg::OP_GET_NEXT;
            if (r < 65) return ulst_pkg::OP_RESET_CURSOR;
            if (r < 78) return ulst_pkg::OP_INSERT;
            if (r < 91) return ulst_pkg::OP_DELETE;
            return ulst_pkg::OP_RETRIEVE;
         end
         default: begin
            if (r < 20) return ulst_pkg::OP_INSERT;
            if (r < 38) return ulst_pkg::OP_DELETE;
            if (r < 53) return ulst_pkg::OP_RETRIEVE;
            if (r < 63) return ulst_pkg::OP_RESET_CURSOR;
            if (r < 83) return ulst_pkg::OP_GET_NEXT;
            if (r < 90) return ulst_pkg::OP_MAKE_EMPTY;
            return r[0] ? OP_SPARE_LO : OP_SPARE_HI;
         end
      endcase
   endfunction

   // Mostly values already held or from a small pool, so deletes and retrieves hit.
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && shadow_count > 0)
         return shadow_entries[$urandom_range(0, shadow_count - 1)];
      if (r < 75) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Response checker and watchdog.
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got.item_out = rsp_tdata[31:0];
            got.found    = rsp_tdata[32];
            got.status   = rsp_tdata[34:33];
            got.count    = rsp_tdata[39:35];
            got.at_end   = rsp_tdata[40];
            if (pending_results.size() == 0) begin
               report_mismatch("response with none pending", rsp_tdata[31:0], 32'h0);
            end else begin
               want = pending_results.pop_front();
               if (got.item_out != want.item_out)
                  report_mismatch("item_out", got.item_out, want.item_out);
               if (got.found != want.found)
                  report_mismatch("found", 32'(got.found), 32'(want.found));
               if (got.status != want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.count != want.count)
                  report_mismatch("count", 32'(got.count), 32'(want.count));
               if (got.at_end != want.at_end)
                  report_mismatch("at_end", 32'(got.at_end), 32'(want.at_end));
               if (rsp_tdata[47:41] != '0)
                  report_mismatch("zero fill", 32'(rsp_tdata[47:41]), 32'h0);
            end
            resp_count++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: nothing moved for %0d cycles, %0d responses outstanding",
                     IDLE_LIMIT, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Response side back-pressure: random stalls, steady stretches, one long hold-off.
   initial begin
      int stall_left;
      int r;
      bit steady;
      rsp_tready = 1'b0;
      stall_left = 0;
      steady     = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            stall_left    = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if ($urandom_range(0, 149) == 0) steady = !steady;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
         end
      end
   end

   // Stimulus.
   initial begin
      phase_kind_type kind;
      int phase_no;
      int phase_len;
      int random_sent;
      int total;
      int i;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      error_count   = 0;
      resp_count    = 0;
      idle_cycles   = 0;
      full_drops    = 0;
      match_hits    = 0;
      past_end_hits = 0;
      burst_mode    = 1'b0;
      long_hold_req = 1'b0;
      shadow_count  = 0;
      shadow_cursor = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h0000_0001;
      value_pool[3] = 32'h8000_0000;
      for (i = 4; i < 8; i++) value_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: every lookup misses, get next is past the end
      add_row(ulst_pkg::OP_GET_NEXT, 32'h0000_0000, 1, 32'h0, 0, ulst_pkg::STAT_PAST_END, 0, 1);
      add_row(ulst_pkg::OP_RETRIEVE, 32'h0000_0000, 1, 32'h0, 0, ulst_pkg::STAT_NOT_FOUND, 0, 1);
      add_row(ulst_pkg::OP_DELETE, 32'hFFFF_FFFF, 1, 32'h0, 0, ulst_pkg::STAT_NOT_FOUND, 0, 1);
      // value extremes; cursor keeps standing past the end on insert
      add_row(ulst_pkg::OP_INSERT, 32'h0000_0000, 1, 32'h0, 0, ulst_pkg::STAT_OK, 1, 1);
      add_row(ulst_pkg::OP_INSERT, 32'hFFFF_FFFF, 1, 32'h0, 0, ulst_pkg::STAT_OK, 2, 1);
      add_row(ulst_pkg::OP_INSERT, 32'hA5A5_5A5A, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_RETRIEVE, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, ulst_pkg::STAT_OK, 3, 1);
      add_row(ulst_pkg::OP_RESET_CURSOR, 32'h1234_5678, 1, 32'h0, 0, ulst_pkg::STAT_OK, 3, 0);
      add_row(ulst_pkg::OP_GET_NEXT, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      // insert and delete ahead of the cursor: it must follow its entry
      add_row(ulst_pkg::OP_INSERT, 32'h0000_0001, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_DELETE, 32'hA5A5_5A5A, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_GET_NEXT, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      // delete the entry under the cursor: it moves on to the follower
      add_row(ulst_pkg::OP_RESET_CURSOR, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_GET_NEXT, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_DELETE, 32'hFFFF_FFFF, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_GET_NEXT, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_GET_NEXT, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      // spare codes change nothing
      add_row(OP_SPARE_LO, 32'hFFFF_FFFF, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(OP_SPARE_HI, 32'h0000_0000, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      // delete miss, then duplicates: delete takes the one nearest the head
      add_row(ulst_pkg::OP_DELETE, 32'h1234_5678, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_INSERT, 32'h0000_0001, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_DELETE, 32'h0000_0001, 0, 32'h0, 0, ulst_pkg::STAT_OK, 0, 0);
      add_row(ulst_pkg::OP_MAKE_EMPTY, 32'h0000_0000, 1, 32'h0, 0, ulst_pkg::STAT_OK, 0, 1);
      add_row(ulst_pkg::OP_RETRIEVE, 32'h0000_0001, 1, 32'h0, 0, ulst_pkg::STAT_NOT_FOUND, 0, 1);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
      wait_for_drain();

      // random phases, each biased toward one kind of traffic
      phase_no    = 0;
      random_sent = 0;
      while (random_sent < RANDOM_REQS) begin
         kind       = phase_kind_type'($urandom_range(0, 4));
         phase_len  = $urandom_range(20, 80);
         burst_mode = ($urandom_range(0, 3) == 0);
         if (phase_no == 3) begin
            // receiver holds off while requests keep coming back to back
            burst_mode    = 1'b1;
            long_hold_req = 1'b1;
            phase_len     = 60;
         end
         if (kind == PH_CLEAR) begin
            send_request(ulst_pkg::OP_MAKE_EMPTY, $urandom, 1'b0, '0);
            random_sent++;
         end
         if (kind == PH_WALK) begin
            send_request(ulst_pkg::OP_RESET_CURSOR, $urandom, 1'b0, '0);
            random_sent++;
         end
         repeat (phase_len) begin
            send_request(pick_op(kind), pick_value(), 1'b0, '0);
            random_sent++;
         end
         if ($urandom_range(0, 5) == 0) wait_for_drain();
         phase_no++;
      end

      wait_for_drain();
      repeat (DRAIN_WAIT) @(posedge clock);

      total = 0;
      foreach (op_seen[i]) total += op_seen[i];
      $display("Ran %0d requests: ins %0d del %0d ret %0d rst %0d nxt %0d clr %0d spare %0d",
               total, op_seen[ulst_pkg::OP_INSERT], op_seen[ulst_pkg::OP_DELETE],
               op_seen[ulst_pkg::OP_RETRIEVE], op_seen[ulst_pkg::OP_RESET_CURSOR],
               op_seen[ulst_pkg::OP_GET_NEXT], op_seen[ulst_pkg::OP_MAKE_EMPTY],
               op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI]);
      $display("Full drops %0d, lookup hits %0d, past-end reads %0d, responses checked %0d",
               full_drops, match_hits, past_end_hits, resp_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
